// ===== src/rds_pkg.sv =====
// Shared widths, register codes and saturation helper for the relative difference stencil.
package rds_pkg;

  // Field widths of the stream payload and the configuration registers.
  localparam int SAMPLE_W = 32;
  localparam int RATIO_W  = 32;
  localparam int IDX_W    = 6;
  localparam int MAX_W    = 31;
  localparam int SCALE_W  = 16;
  localparam int THR_W    = 31;

  // Stream bus widths: the output tdata carries ratio, cell index and block maximum.
  localparam int S_TDATA_W  = SAMPLE_W;
  localparam int M_FIELDS_W = RATIO_W + IDX_W + MAX_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = THR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARSE_THR = 1'b1;
  localparam logic [SCALE_W-1:0]   SCALE_RESET    = 16'd256;

  // Stencil geometry.
  localparam int PAD_W              = 1;
  localparam int CELLS_PER_SIDE_DEF = 4;

  // Arithmetic widths: step magnitude, denominator, quotient and scaling shift.
  localparam int STEP_W      = 32;
  localparam int DEN_W       = SAMPLE_W + SCALE_W;
  localparam int Q_W         = 32;
  localparam int FRAC_SHIFT  = 24;
  localparam int MUL_DIGIT_W = 4;
  localparam int MUL_STEPS   = SCALE_W / MUL_DIGIT_W;

  // Cell information handed from the sample window to the control logic.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } rds_cell_t;

  // Turns one raw quotient into a saturated signed Q16.16 direction ratio.
  function automatic logic signed [RATIO_W-1:0] rds_sat_ratio(
    input logic           step_zero,
    input logic           den_zero,
    input logic           neg,
    input logic           ovf,
    input logic [Q_W-1:0] quot
  );
    logic                   big;
    logic [RATIO_W-1:0]     sat_pos;
    logic [RATIO_W-1:0]     sat_neg;
    logic [RATIO_W-1:0]     res;
    sat_pos = {1'b0, {(RATIO_W-1){1'b1}}};
    sat_neg = {1'b1, {(RATIO_W-1){1'b0}}};
    big     = ovf || quot[Q_W-1];
    if (step_zero) begin
      res = '0;
    end else if (den_zero) begin
      res = sat_pos;
    end else if (!neg) begin
      res = big ? sat_pos : RATIO_W'(quot);
    end else begin
      res = big ? sat_neg : RATIO_W'(~quot + 1'b1);
    end
    return $signed(res);
  endfunction

endpackage

// ===== src/rds_win.sv =====
// Sample window: delay line, padded position counters and inner cell decode.
module rds_win
  import rds_pkg::*;
#(
  parameter int CELLS_PER_SIDE = CELLS_PER_SIDE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       block_start_i,
  output rds_cell_t                  cell_o,
  output logic signed [SAMPLE_W-1:0] cen_o,
  output logic signed [SAMPLE_W-1:0] xl_o,
  output logic signed [SAMPLE_W-1:0] xr_o,
  output logic signed [SAMPLE_W-1:0] yl_o
);

  localparam int PADDED = CELLS_PER_SIDE + 2 * PAD_W;
  localparam int DEPTH  = 2 * PADDED;
  localparam int CW     = $clog2(PADDED);
  localparam logic [CW-1:0] C_END  = CW'(PADDED - 1);
  localparam logic [CW-1:0] C_LO   = CW'(PAD_W);
  localparam logic [CW-1:0] C_HI   = CW'(CELLS_PER_SIDE);
  localparam logic [CW-1:0] Y_LO   = CW'(PAD_W + 1);
  localparam logic [CW-1:0] Y_HI   = CW'(CELLS_PER_SIDE + 1);

  logic signed [SAMPLE_W-1:0] dl_q [DEPTH];
  logic [CW-1:0]    x_q, y_q, z_q;
  logic [CW-1:0]    x_e, y_e, z_e;
  logic             done_q;
  logic [IDX_W-1:0] idx_q, idx_e;
  logic             active;
  logic             is_cell;

  // A block start restarts the scan at padded sample zero.
  assign x_e    = block_start_i ? '0 : x_q;
  assign y_e    = block_start_i ? '0 : y_q;
  assign z_e    = block_start_i ? '0 : z_q;
  assign idx_e  = block_start_i ? '0 : idx_q;
  assign active = block_start_i || !done_q;

  // A cell is emitted when its upper y neighbour arrives.
  assign is_cell = active && (x_e >= C_LO) && (x_e <= C_HI) && (y_e >= Y_LO) &&
                   (y_e <= Y_HI) && (z_e >= C_LO) && (z_e <= C_HI);

  assign cell_o.valid = is_cell;
  assign cell_o.last  = (x_e == C_HI) && (y_e == Y_HI) && (z_e == C_HI);
  assign cell_o.idx   = idx_e;

  // Fixed taps of the delay line around the centre cell.
  assign cen_o = dl_q[PADDED-1];
  assign xl_o  = dl_q[PADDED];
  assign xr_o  = dl_q[PADDED-2];
  assign yl_o  = dl_q[DEPTH-1];

  // Position counters and cell numbering.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else if (take_i && active) begin
      idx_q  <= idx_e + IDX_W'(is_cell);
      done_q <= 1'b0;
      if (x_e != C_END) begin
        x_q <= x_e + 1'b1;
        y_q <= y_e;
        z_q <= z_e;
      end else begin
        x_q <= '0;
        if (y_e != C_END) begin
          y_q <= y_e + 1'b1;
          z_q <= z_e;
        end else begin
          y_q <= '0;
          if (z_e != C_END) begin
            z_q <= z_e + 1'b1;
          end else begin
            z_q    <= '0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  // Delay line of the last two padded rows.
  always_ff @(posedge clk_i) begin
    if (take_i && active) begin
      dl_q[0] <= sample_i;
      for (int i = 1; i < DEPTH; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

endmodule

// ===== src/rds_mul.sv =====
// Digit-serial multiplier: center magnitude times scale, one radix-16 digit per cycle.
module rds_mul
  import rds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SAMPLE_W-1:0] mag_i,
  input  logic [SCALE_W-1:0]  scale_i,
  output logic [DEN_W-1:0]    den_o,
  output logic                done_o
);

  localparam int CNT_W = $clog2(MUL_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);

  logic                            busy_q;
  logic                            done_q;
  logic [CNT_W-1:0]                cnt_q;
  logic [SAMPLE_W-1:0]             mag_q;
  logic [SCALE_W-1:0]              dig_q;
  logic [DEN_W-1:0]                acc_q;
  logic [MUL_DIGIT_W-1:0]          digit;
  logic [SAMPLE_W+MUL_DIGIT_W-1:0] pp;
  logic [DEN_W-1:0]                acc_d;

  // Most significant scale digit first: shift the sum and add one partial product.
  assign digit = dig_q[SCALE_W-1 -: MUL_DIGIT_W];
  assign pp    = mag_q * digit;
  assign acc_d = {acc_q[DEN_W-MUL_DIGIT_W-1:0], MUL_DIGIT_W'(0)} + DEN_W'(pp);

  assign den_o  = acc_q;
  assign done_o = done_q;

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand shift register and accumulator.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      dig_q <= scale_i;
      acc_q <= '0;
    end else if (busy_q) begin
      dig_q <= {dig_q[SCALE_W-MUL_DIGIT_W-1:0], MUL_DIGIT_W'(0)};
      acc_q <= acc_d;
    end
  end

endmodule

// ===== src/rds_div.sv =====
// Bit-serial restoring divider: (step << 24) / den, one quotient bit per cycle.
module rds_div
  import rds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [STEP_W-1:0] step_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [Q_W-1:0]    quot_o,
  output logic              ovf_o,
  output logic              done_o
);

  localparam int CNT_W  = $clog2(Q_W);
  localparam int HI_LSB = Q_W - FRAC_SHIFT;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [Q_W-1:0]   num_q;
  logic [Q_W-1:0]   quot_q;
  logic             ovf_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift in the next numerator bit and subtract where the divisor fits.
  assign trial = {rem_q, num_q[Q_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;
  assign done_o = done_q;

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder, numerator and quotient shift registers. The quotient cannot fit
  // in its bits when the upper numerator part alone already reaches the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DEN_W'(step_i[STEP_W-1:HI_LSB]);
      num_q <= {step_i[HI_LSB-1:0], FRAC_SHIFT'(0)};
      den_q <= den_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        ovf_q <= rem_q >= den_q;
      end
      rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_q  <= {num_q[Q_W-2:0], 1'b0};
      quot_q <= {quot_q[Q_W-2:0], ge};
    end
  end

endmodule

// ===== src/relative_difference_stencil.sv =====
// Top level of the relative difference stencil: control, configuration and output register.
//
// The block takes a padded cube of Q4.28 samples in x-fastest order and, for
// every inner cell, returns the larger of its x and y relative differences in
// saturated Q16.16, with the block maximum on the last cell. A padded sample
// that closes no cell is taken while the sequencer stays idle. A cell goes from
// its transaction through the states PREP, which forms the magnitudes, and
// CHECK, which forms the steps and the skip decision, then MUL, where the
// radix-16 multiplier builds center times scale from four digits, then DIV,
// where the two bit-serial dividers work on x and y side by side for 32
// quotient bits, and FIN, which loads the output register. A skipped cell
// goes from CHECK straight to FIN. The result waits in an output register,
// so the next sample is taken as soon as the output slot is free or being
// drained.
module relative_difference_stencil
  import rds_pkg::*;
#(
  parameter int CELLS_PER_SIDE = CELLS_PER_SIDE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] sample
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [0] block_start
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] ratio, [37:32] cell_index, [68:38] block_max, rest zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // [0] skipped
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q;

  logic [SCALE_W-1:0] scale_q;
  logic [THR_W-1:0]   thr_q;
  logic [MAX_W-1:0]   run_max_q;

  logic                       in_acc;
  rds_cell_t                  win_cell;
  logic signed [SAMPLE_W-1:0] tap_c, tap_xl, tap_xr, tap_yl;

  logic signed [SAMPLE_W-1:0] cen_q, xl_q, xr_q, yl_q, yr_q;
  logic                       last_q;
  logic [IDX_W-1:0]           idx_q;
  logic [SAMPLE_W-1:0]        cmag_q;
  logic                       negc_q;
  logic [STEP_W-1:0]          mxl_q, mxr_q, myl_q, myr_q;
  logic [STEP_W-1:0]          stepx_q, stepy_q;
  logic                       skip_q;
  logic                       skip_now;
  logic signed [RATIO_W-1:0]  ratio_q;

  logic                      mul_start, mul_done;
  logic [DEN_W-1:0]          den;
  logic [Q_W-1:0]            quot_x, quot_y;
  logic                      ovf_x, ovf_y, done_x, done_y;
  logic signed [RATIO_W-1:0] rx, ry;
  logic [MAX_W-1:0]          new_max;
  logic                      out_free;
  logic                      out_load;

  logic                      out_valid_q;
  logic [RATIO_W-1:0]        out_ratio_q;
  logic [IDX_W-1:0]          out_idx_q;
  logic                      out_skip_q;
  logic                      out_last_q;
  logic [MAX_W-1:0]          out_bmax_q;

  // Magnitude of the difference of two samples.
  function automatic logic [STEP_W-1:0] mag_diff(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [SAMPLE_W:0] d;
    d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    return d[SAMPLE_W] ? STEP_W'(~d + 1'b1) : STEP_W'(d);
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = (state_q == ST_FIN) && out_free;

  rds_win #(
    .CELLS_PER_SIDE(CELLS_PER_SIDE)
  ) u_win (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (in_acc),
    .sample_i      ($signed(s_axis_tdata[SAMPLE_W-1:0])),
    .block_start_i (s_axis_tuser),
    .cell_o        (win_cell),
    .cen_o         (tap_c),
    .xl_o          (tap_xl),
    .xr_o          (tap_xr),
    .yl_o          (tap_yl)
  );

  // Cells whose center magnitude is below the threshold bypass the arithmetic.
  assign skip_now  = cmag_q < {1'b0, thr_q};
  assign mul_start = (state_q == ST_CHECK) && !skip_now;

  rds_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mag_i   (cmag_q),
    .scale_i (scale_q),
    .den_o   (den),
    .done_o  (mul_done)
  );

  rds_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_done),
    .step_i  (stepx_q),
    .den_i   (den),
    .quot_o  (quot_x),
    .ovf_o   (ovf_x),
    .done_o  (done_x)
  );

  rds_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_done),
    .step_i  (stepy_q),
    .den_i   (den),
    .quot_o  (quot_y),
    .ovf_o   (ovf_y),
    .done_o  (done_y)
  );

  // Saturated direction ratios once both quotients are ready.
  assign rx = rds_sat_ratio(stepx_q == '0, den == '0, negc_q, ovf_x, quot_x);
  assign ry = rds_sat_ratio(stepy_q == '0, den == '0, negc_q, ovf_y, quot_y);

  // Only positive ratios of cells that were not skipped raise the maximum.
  assign new_max = (!skip_q && !ratio_q[RATIO_W-1] && (ratio_q[MAX_W-1:0] > run_max_q)) ?
                   ratio_q[MAX_W-1:0] : run_max_q;

  // Sequencer, configuration registers, running maximum and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scale_q     <= SCALE_RESET;
      thr_q       <= '0;
      run_max_q   <= '0;
      out_valid_q <= 1'b0;
      out_ratio_q <= '0;
      out_idx_q   <= '0;
      out_skip_q  <= 1'b0;
      out_last_q  <= 1'b0;
      out_bmax_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIFF_SCALE: scale_q <= cfg_data_i[SCALE_W-1:0];
          CFG_SPARSE_THR: thr_q   <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser) begin
              run_max_q <= '0;
            end
            if (win_cell.valid) begin
              state_q <= ST_PREP;
            end
          end
        end
        ST_PREP: state_q <= ST_CHECK;
        ST_CHECK: state_q <= skip_now ? ST_FIN : ST_MUL;
        ST_MUL: begin
          if (mul_done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (done_x) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ratio_q <= ratio_q;
            out_idx_q   <= idx_q;
            out_skip_q  <= skip_q;
            out_last_q  <= last_q;
            out_bmax_q  <= last_q ? new_max : '0;
            run_max_q   <= new_max;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Operand capture and per-cell working values.
  always_ff @(posedge clk_i) begin
    if (in_acc && win_cell.valid) begin
      cen_q  <= tap_c;
      xl_q   <= tap_xl;
      xr_q   <= tap_xr;
      yl_q   <= tap_yl;
      yr_q   <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
      last_q <= win_cell.last;
      idx_q  <= win_cell.idx;
    end
    if (state_q == ST_PREP) begin
      cmag_q <= cen_q[SAMPLE_W-1] ? (~cen_q + 1'b1) : cen_q;
      negc_q <= cen_q[SAMPLE_W-1];
      mxl_q  <= mag_diff(cen_q, xl_q);
      mxr_q  <= mag_diff(xr_q, cen_q);
      myl_q  <= mag_diff(cen_q, yl_q);
      myr_q  <= mag_diff(yr_q, cen_q);
    end
    if (state_q == ST_CHECK) begin
      skip_q  <= skip_now;
      stepx_q <= (mxl_q > mxr_q) ? mxl_q : mxr_q;
      stepy_q <= (myl_q > myr_q) ? myl_q : myr_q;
      if (skip_now) begin
        ratio_q <= '0;
      end
    end
    if ((state_q == ST_DIV) && done_x) begin
      ratio_q <= (rx > ry) ? rx : ry;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), out_bmax_q, out_idx_q, out_ratio_q};
  assign m_axis_tuser  = out_skip_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  // The two dividers start together and must finish together.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_x == done_y)
    else $error("x and y dividers out of step");

  // The multiplier reports completion only while the sequencer waits for it.
  a_mul_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL))
    else $error("multiplier finished outside its wait state");

  // A skipped cell always reports a zero ratio.
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_skip_q) |-> (out_ratio_q == '0))
    else $error("skipped cell with nonzero ratio");

  // The block maximum is only reported with the last cell.
  a_bmax_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_bmax_q == '0))
    else $error("block maximum outside the last cell");

  // A result waiting in the output register is not replaced.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_idx_q)))
    else $error("pending result overwritten");
`endif

endmodule

// ===== tb/relative_difference_stencil_tb.sv =====
// Self-checking stream testbench for the relative difference stencil with a cell-level predictor.
`timescale 1ns / 100ps

module relative_difference_stencil_tb
  import rds_pkg::*;
();

  // Stencil geometry as seen by the predictor.
  localparam int CELLS  = CELLS_PER_SIDE_DEF;
  localparam int PADDED = CELLS + 2 * PAD_W;
  localparam int WIN    = 2 * PADDED;
  localparam int TOTAL  = PADDED * PADDED * PADDED;

  // Run control: settle time after the last cell, receiver hold-off and timeout.
  localparam int SETTLE      = 64;
  localparam int HOLD_CYCLES = 500;
  localparam int LIMIT       = 1000000;

  localparam logic signed [63:0] SAT_POS = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] SAT_NEG = -64'sh8000_0000;

  // Flavors of random block content.
  typedef enum int unsigned {
    SHAPE_SMOOTH,
    SHAPE_WIDE,
    SHAPE_FLAT,
    SHAPE_SPARSE
  } shape_e;

  // One expected cell as it leaves the block.
  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [IDX_W-1:0]   idx;
    logic               skipped;
    logic               last;
    logic [MAX_W-1:0]   bmax;
  } cell_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;
  int cycles;

  // Predicts the cells of each block and checks them in arrival order.
  class stencil_scoreboard;
    logic signed [SAMPLE_W-1:0] window [WIN];
    int unsigned                pos;
    logic signed [63:0]         peak;
    logic [SCALE_W-1:0]         scale;
    logic [THR_W-1:0]           thr;
    cell_result_t               expected_cells[$];
    int                         errors;

    function new();
      foreach (window[i]) window[i] = '0;
      pos    = 0;
      peak   = 0;
      scale  = SCALE_RESET;
      thr    = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_DIFF_SCALE) begin
        scale = val[SCALE_W-1:0];
      end else if (idx == CFG_SPARSE_THR) begin
        thr = val[THR_W-1:0];
      end
    endfunction

    function logic [63:0] mag(logic signed [63:0] v);
      return (v < 0) ? -v : v;
    endfunction

    // Relative step along one axis, saturated to Q16.16.
    function logic signed [63:0] rel_step(logic signed [63:0] lft, logic signed [63:0] cen,
                                          logic signed [63:0] rgt);
      logic [63:0] dl;
      logic [63:0] dr;
      logic [63:0] st;
      logic [63:0] den;
      logic [63:0] q;
      dl  = mag(cen - lft);
      dr  = mag(rgt - cen);
      st  = (dl > dr) ? dl : dr;
      den = mag(cen) * 64'(scale);
      if (st == 0) return 0;
      if (den == 0) return SAT_POS;
      q = (st << FRAC_SHIFT) / den;
      if (cen >= 0) return (q > 64'h7FFF_FFFF) ? SAT_POS : $signed(q);
      return (q >= 64'h8000_0000) ? SAT_NEG : -$signed(q);
    endfunction

    // Called for every accepted sample transaction.
    function void note_sample(logic [SAMPLE_W-1:0] smp, logic start);
      logic signed [SAMPLE_W-1:0] s;
      logic signed [63:0]         cen;
      logic signed [63:0]         rx;
      logic signed [63:0]         ry;
      logic signed [63:0]         r;
      logic                       skip;
      logic                       last;
      int                         x;
      int                         y;
      int                         z;
      cell_result_t               c;
      s = smp;
      if (start) begin
        pos  = 0;
        peak = 0;
      end
      // Samples past the end of a block are dropped without a trace.
      if (pos >= TOTAL) return;
      x = pos % PADDED;
      y = (pos / PADDED) % PADDED;
      z = pos / (PADDED * PADDED);
      // A cell is complete once its +y neighbor is the current sample.
      if (x >= 1 && x <= CELLS && y >= 2 && y <= CELLS + 1 && z >= 1 && z <= CELLS) begin
        cen  = window[PADDED-1];
        r    = 0;
        skip = mag(cen) < 64'(thr);
        last = (x == CELLS) && (y == CELLS + 1) && (z == CELLS);
        if (!skip) begin
          rx = rel_step(window[PADDED], cen, window[PADDED-2]);
          ry = rel_step(window[WIN-1], cen, s);
          r  = (rx > ry) ? rx : ry;
          if (r > peak) peak = r;
        end
        c.ratio   = r[RATIO_W-1:0];
        c.idx     = IDX_W'((x - 1) + CELLS * ((y - 2) + CELLS * (z - 1)));
        c.skipped = skip;
        c.last    = last;
        c.bmax    = last ? peak[MAX_W-1:0] : '0;
        expected_cells.push_back(c);
      end
      for (int i = WIN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = s;
      pos++;
    endfunction

    task report_mismatch(string what, logic [M_TDATA_W-1:0] got, logic [M_TDATA_W-1:0] want);
      if (errors < 200) begin
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
      end
      errors++;
    endtask

    // Called for every accepted cell transaction.
    task check_cell(logic [M_TDATA_W-1:0] data, logic skp, logic lst);
      cell_result_t want;
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected cell", data, '0);
        return;
      end
      want = expected_cells.pop_front();
      if (data[RATIO_W-1:0] !== want.ratio)
        report_mismatch("ratio", data[RATIO_W-1:0], want.ratio);
      if (data[RATIO_W +: IDX_W] !== want.idx)
        report_mismatch("cell_index", data[RATIO_W +: IDX_W], want.idx);
      if (data[RATIO_W+IDX_W +: MAX_W] !== want.bmax)
        report_mismatch("block_max", data[RATIO_W+IDX_W +: MAX_W], want.bmax);
      if ((data >> M_FIELDS_W) !== '0)
        report_mismatch("tdata padding", data >> M_FIELDS_W, '0);
      if (skp !== want.skipped)
        report_mismatch("skipped", skp, want.skipped);
      if (lst !== want.last)
        report_mismatch("last_cell", lst, want.last);
    endtask
  endclass

  stencil_scoreboard sb;

  relative_difference_stencil u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Cycle counter guarding against a hung run.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[relative_difference_stencil] ERROR");
      $finish;
    end
  end

  // Receiver: random backpressure, plus a long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every cell transaction goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_cell(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Offers one sample and returns at the falling edge after its transaction.
  task automatic send_item(input logic [S_TDATA_W-1:0] smp, input logic start);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      s_axis_tuser  <= 1'($urandom_range(1));
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(smp, start);
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every predicted cell has come out.
  task automatic hold_sender();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Drained and given time to finish any sample still in flight.
  task automatic wait_idle();
    hold_sender();
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Hand-picked values: extremes, zero centers, sign changes, flat and all-zero layers.
  function automatic logic [S_TDATA_W-1:0] extreme_sample(int p);
    int z;
    z = p / (PADDED * PADDED);
    if (z == 3) return 32'h0100_0000;
    if (z == 4) return '0;
    case (p % 9)
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'h1000_0000;
      6: return 32'hF000_0000;
      7: return 32'h0000_0000;
      default: return 32'h0000_0003;
    endcase
  endfunction

  function automatic logic [S_TDATA_W-1:0] make_sample(shape_e shape, logic [S_TDATA_W-1:0] base);
    case (shape)
      SHAPE_SMOOTH: return base + 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      SHAPE_WIDE:   return $urandom;
      SHAPE_FLAT:   return ($urandom_range(15) == 0) ? base + 32'($urandom_range(255)) : base;
      default:      return ($urandom_range(3) != 0) ? 32'($urandom_range(255)) : $urandom;
    endcase
  endfunction

  // One padded block, sometimes preceded by an abandoned partial block and
  // followed by stray samples that the block must drop.
  task automatic feed_block(input shape_e shape, input int pause_at);
    logic [S_TDATA_W-1:0] base;
    int unsigned          cut;
    if (shape == SHAPE_FLAT && $urandom_range(1) == 0) begin
      base = '0;
    end else begin
      base = 32'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
    end
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(1, TOTAL - 1);
      for (int p = 0; p < cut; p++) send_item(make_sample(shape, base), p == 0);
    end
    for (int p = 0; p < TOTAL; p++) begin
      if (p == pause_at) hold_sender();
      send_item(make_sample(shape, base), p == 0);
    end
    repeat ($urandom_range(2)) send_item($urandom, 1'b0);
  endtask

  task automatic run_phase(input logic [SCALE_W-1:0] scale, input logic [THR_W-1:0] thr,
                           input int sp, input int rp, input bit stress);
    write_reg(CFG_DIFF_SCALE, CFG_DATA_W'(scale));
    write_reg(CFG_SPARSE_THR, CFG_DATA_W'(thr));
    send_idle_pct = sp;
    recv_idle_pct = rp;
    if (stress) hold_req = 1'b1;
    feed_block(shape_e'($urandom_range(3)), stress ? TOTAL / 2 : -1);
    wait_idle();
  endtask

  // Main sequence.
  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DIFF_SCALE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    send_idle_pct = 7;
    recv_idle_pct = 81;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed block at the reset settings, then two samples past its end.
    for (int p = 0; p < TOTAL; p++) send_item(extreme_sample(p), p == 0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    wait_idle();

    // Random blocks across register settings and idling patterns.
    run_phase(16'hFFFF, '0, 81, 7, 1'b0);
    run_phase(16'd0, THR_W'($urandom_range(1, 255)), 81, 7, 1'b0);
    run_phase(SCALE_W'($urandom_range(1, 65535)), THR_W'($urandom_range(0, 1 << 24)), 0, 0,
              1'b1);
    run_phase(16'd256, {THR_W{1'b1}}, 0, 0, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[relative_difference_stencil] OK");
    end else begin
      $display("[relative_difference_stencil] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rds_pkg.sv
src/rds_win.sv
src/rds_mul.sv
src/rds_div.sv
src/relative_difference_stencil.sv
tb/relative_difference_stencil_tb.sv
